@@ rtl/core/hdc_ngr_pkg.sv @@
// Package for the hyperdimensional n-gram encoder: sizes, item codes and
// the records passed between the front end, the op queue and the back end.
// No dependencies.
package hdc_ngr_pkg;

  // Hypervector and encoder sizes
  localparam int DIM       = 64;
  localparam int NGRAM     = 4;
  localparam int ENTRIES   = 27;
  localparam int SUM_WIDTH = 32;

  // Port field widths
  localparam int KIND_W    = 2;
  localparam int SLOT_W    = 5;
  localparam int SYMBOL_W  = 8;
  localparam int HV_W      = 64;
  localparam int SUM_IDX_W = 6;
  localparam int SUM_OUT_W = 32;

  localparam int DIM_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ENT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(NGRAM + 1);

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    kind_e                kind;
    logic                 hit;
    logic [DIM-1:0]       vec;
    logic [SUM_IDX_W-1:0] sum_index;
  } op_t;

  typedef struct packed {
    logic signed [SUM_OUT_W-1:0] sum_value;
    logic [SUM_IDX_W-1:0]        sum_position;
  } res_t;

endpackage

@@ rtl/core/hdc_ngr_front.sv @@
// Front end: accepts requests, keeps the item memory and does the symbol lookup.
// Depends on hdc_ngr_pkg.
module hdc_ngr_front import hdc_ngr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 q_full_i,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [SYMBOL_W-1:0]  symbol_i,
  input  logic [HV_W-1:0]      hv_bits_i,
  input  logic [SUM_IDX_W-1:0] sum_index_i,
  output logic                 q_push_o,
  output op_t                  q_op_o
);

  logic [SYMBOL_W-1:0] sym_q [ENTRIES];
  logic [DIM-1:0]      vec_q [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;

  logic             accept;
  kind_e            kind;
  logic             load_en;
  logic             hit;
  logic [ENT_W-1:0] hit_idx;

  assign accept  = push_i && !q_full_i;
  assign kind    = kind_e'(kind_i);
  assign load_en = accept && (kind == KIND_LOAD) &&
                   ({1'b0, slot_i} < (SLOT_W+1)'(ENTRIES));

  // Lowest matching valid entry wins: scan downward so the last hit stands.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (sym_q[i] == symbol_i)) begin
        hit     = 1'b1;
        hit_idx = ENT_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        sym_q[i] <= '0;
      end
    end else if (load_en) begin
      valid_q[ENT_W'(slot_i)] <= 1'b1;
      sym_q[ENT_W'(slot_i)]   <= symbol_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      vec_q[ENT_W'(slot_i)] <= hv_bits_i[DIM-1:0];
    end
  end

  // Loads are finished here; everything else goes to the back end.
  assign q_push_o         = accept && (kind != KIND_LOAD);
  assign q_op_o.kind      = kind;
  assign q_op_o.hit       = hit;
  assign q_op_o.vec       = vec_q[hit_idx];
  assign q_op_o.sum_index = sum_index_i;

endmodule

@@ rtl/core/hdc_ngr_queue.sv @@
// Two-entry op queue between front end and back end.
// Depends on hdc_ngr_pkg.
module hdc_ngr_queue import hdc_ngr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  op_o
);

  op_t        ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign op_o    = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

@@ rtl/core/hdc_ngr_back.sv @@
// Back end: block rows, n-gram binding, saturating sum lanes, result buffer.
// Depends on hdc_ngr_pkg.
module hdc_ngr_back import hdc_ngr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  op_t  q_op_i,
  output logic q_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  logic [DIM-1:0]              rows_q [NGRAM];
  logic [DIM-1:0]              rows_d [NGRAM];
  logic [CNT_W-1:0]            seen_q, seen_d;
  logic signed [SUM_WIDTH-1:0] sum_q [DIM];
  logic signed [SUM_WIDTH-1:0] sum_d [DIM];
  logic [DIM-1:0]              gram;
  logic [DIM-1:0]              odd_minus;

  res_t       res_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       res_push, res_pop;
  res_t       res_new;

  logic exec, do_sym, do_clr, do_acc;

  // A read needs a free result slot; other ops always go.
  assign exec    = !q_empty_i && ((q_op_i.kind != KIND_READ) || (cnt_q != 2'd2));
  assign q_pop_o = exec;
  assign do_sym  = exec && (q_op_i.kind == KIND_SYMBOL);
  assign do_clr  = exec && (q_op_i.kind == KIND_CLEAR);
  assign do_acc  = do_sym && (seen_q == CNT_W'(NGRAM));

  // Row move with wrap, rotate by one component; new row 0 from lookup on a hit, else the wrapped last row.
  always_comb begin
    for (int i = 1; i < NGRAM; i++) begin
      rows_d[i] = {rows_q[i-1][DIM-2:0], rows_q[i-1][DIM-1]};
    end
    rows_d[0] = q_op_i.hit ? q_op_i.vec
                           : {rows_q[NGRAM-1][DIM-2:0], rows_q[NGRAM-1][DIM-1]};
    odd_minus = '0;
    for (int i = 0; i < NGRAM; i++) begin
      odd_minus = odd_minus ^ ~rows_d[i];
    end
    gram = ~odd_minus;
  end

  always_comb begin
    seen_d = seen_q;
    if (do_clr) begin
      seen_d = '0;
    end else if (do_sym && !do_acc) begin
      seen_d = seen_q + CNT_W'(1);
    end
  end

  // One saturating +/-1 lane per component
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      sum_d[j] = sum_q[j];
      if (do_clr) begin
        sum_d[j] = '0;
      end else if (do_acc) begin
        if (gram[j]) begin
          if (sum_q[j] != SUM_MAX) sum_d[j] = sum_q[j] + SUM_WIDTH'(1);
        end else begin
          if (sum_q[j] != SUM_MIN) sum_d[j] = sum_q[j] - SUM_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < NGRAM; i++) begin
        rows_q[i] <= '0;
      end
      for (int j = 0; j < DIM; j++) begin
        sum_q[j] <= '0;
      end
    end else begin
      seen_q <= seen_d;
      if (do_sym) begin
        rows_q <= rows_d;
      end
      sum_q <= sum_d;
    end
  end

  // Result buffer, two entries
  always_comb begin
    res_new.sum_position = q_op_i.sum_index;
    res_new.sum_value    = '0;
    if ({1'b0, q_op_i.sum_index} < (SUM_IDX_W+1)'(DIM)) begin
      res_new.sum_value = SUM_OUT_W'(sum_q[q_op_i.sum_index[DIM_W-1:0]]);
    end
  end

  assign res_push = exec && (q_op_i.kind == KIND_READ);
  assign res_pop  = pop_i && (cnt_q != 2'd0);
  assign empty_o  = (cnt_q == 2'd0);
  assign res_o    = res_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ res_push;
      rd_ptr_q <= rd_ptr_q ^ res_pop;
      cnt_q    <= cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[wr_ptr_q] <= res_new;
    end
  end

endmodule

@@ rtl/core/hdc_ngram_accumulator.sv @@
// Hyperdimensional n-gram text encoder, top level; uses hdc_ngr_pkg and the front, queue, back.
// Throughput: one request per cycle, sustained, for any mix of kinds while results are taken.
// A read result reaches the result ports by way of the op queue register
// and then the result buffer.
// Reset (async, active low) clears table valid bits and symbols, block rows,
// symbol count, sums and both queues; table vectors are not reset.
module hdc_ngram_accumulator import hdc_ngr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [KIND_W-1:0]           kind_i,
  input  logic [SLOT_W-1:0]           slot_i,
  input  logic [SYMBOL_W-1:0]         symbol_i,
  input  logic [HV_W-1:0]             hv_bits_i,
  input  logic [SUM_IDX_W-1:0]        sum_index_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic signed [SUM_OUT_W-1:0] sum_value_o,
  output logic [SUM_IDX_W-1:0]        sum_position_o
);

  // Front end stalls only on a full op queue; the back end stalls only
  // when a read finds the result buffer full.
  logic q_push, q_full, q_pop, q_empty;
  op_t  q_op_in, q_op_out;
  res_t res;

  hdc_ngr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .q_full_i    (q_full),
    .kind_i      (kind_i),
    .slot_i      (slot_i),
    .symbol_i    (symbol_i),
    .hv_bits_i   (hv_bits_i),
    .sum_index_i (sum_index_i),
    .q_push_o    (q_push),
    .q_op_o      (q_op_in)
  );

  hdc_ngr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_op_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (q_op_out)
  );

  hdc_ngr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_op_i    (q_op_out),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  // Loads never reach the queue, so the request side is full only when
  // the queue is.
  assign full           = q_full;
  assign sum_value_o    = res.sum_value;
  assign sum_position_o = res.sum_position;

endmodule
